FILE: rtl/core/mded_pkg.sv
// Shared types, constants and helper functions of the multilevel error-diffusion dither.
// Used by the channel interfaces, the row error memory, the quantizer and the top level.
package mded_pkg;

   localparam int MAX_WIDTH_DEFAULT = 2048;
   localparam int CSR_W             = 12;
   localparam int LINE_WIDTH_RESET  = 2048;

   localparam int PIXEL_W = 8;
   localparam int PLANE_W = 5;
   localparam int LEVEL_W = 3;
   localparam int ERR_W   = 12;

   // Corrected pixel value in 1/16 grey steps, and the quantization error.
   localparam int V_W   = 15;
   localparam int E_W   = 14;
   localparam int P_W   = 18;
   localparam int SUM_W = 18;

   localparam int STEP16 = 816;
   localparam int HALF16 = 408;

   localparam logic signed [SUM_W-1:0] ERR_MAX_S = 18'sd2047;
   localparam logic signed [SUM_W-1:0] ERR_MIN_S = -18'sd2048;

   typedef logic signed [ERR_W-1:0] err_type;

   typedef struct packed {
      logic [PLANE_W-1:0] planes;
      logic [LEVEL_W-1:0] level;
      err_type            carry;      // 7/16 share for the right neighbor
      err_type            pend_left;  // next-row error of this column, still without the right neighbor's 3/16 share
      err_type            pend_cur;   // 1/16 share started for the next column
      err_type            wr_left;    // finished next-row error of the column to the left
   } quant_type;

   function automatic err_type sat12(input logic signed [SUM_W-1:0] x);
      err_type r;
      if (x > ERR_MAX_S) begin
         r = err_type'(ERR_MAX_S);
      end else if (x < ERR_MIN_S) begin
         r = err_type'(ERR_MIN_S);
      end else begin
         r = x[ERR_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [LEVEL_W-1:0] planes_to_level(input logic [PLANE_W-1:0] p);
      logic [LEVEL_W-1:0] r;
      unique case (p)
         5'b00000: r = 3'd0;
         5'b00001: r = 3'd1;
         5'b00011: r = 3'd2;
         5'b00111: r = 3'd3;
         5'b01111: r = 3'd4;
         5'b11111: r = 3'd5;
         default:  r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [V_W-1:0] level_base(input logic [LEVEL_W-1:0] lvl);
      logic signed [V_W-1:0] r;
      unique case (lvl)
         3'd0:    r = '0;
         3'd1:    r = V_W'(STEP16);
         3'd2:    r = V_W'(STEP16 * 2);
         3'd3:    r = V_W'(STEP16 * 3);
         3'd4:    r = V_W'(STEP16 * 4);
         3'd5:    r = V_W'(STEP16 * 5);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/core/mded_if.sv
// Valid/ready channel interfaces for pixel requests and dither responses.
// Depends on mded_pkg for the field widths.
interface mded_req_if;
   logic                          valid;
   logic                          ready;
   logic [mded_pkg::PIXEL_W-1:0]  pixel;
   logic                          image_start;

   modport source (output valid, output pixel, output image_start, input ready);
   modport sink   (input valid, input pixel, input image_start, output ready);
endinterface

interface mded_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mded_pkg::PLANE_W-1:0]  planes;
   logic [mded_pkg::LEVEL_W-1:0]  level;
   logic                          row_end;

   modport source (output valid, output planes, output level, output row_end, input ready);
   modport sink   (input valid, input planes, input level, input row_end, output ready);
endinterface

FILE: rtl/core/multilevel_error_diffusion_dither_top.sv
// Top level of the multilevel error-diffusion dither: pipeline control, row memory access.
// Depends on mded_pkg, the mded_req_if/mded_rsp_if interfaces, mded_row_mem and mded_quant.
//
// Grey pixels enter in raster order, one transaction per pixel, and each pixel produces one
// response transaction carrying a six-level quantization (level 0..5), its five-plane
// thermometer code and a row-end flag. The block sustains one pixel per clock while the
// response side is ready and no clearing pass runs. An accepted pixel is registered in the
// quantize stage, and its result then in the response register. The limit is the right-carry
// loop: the 7/16 error share of one pixel feeds the next pixel's quantizer through a single
// register. Errors for the next row live in a synchronous memory of MAX_WIDTH entries, read
// when a pixel is accepted and written back when it is quantized; a write that lands on the
// entry being read in the same cycle is forwarded. At a row end the two last columns both
// finish, so the last column's write is held in a deferred write register and goes out while
// the next row's first pixel, which writes nothing, is processed. After reset the block runs
// a clearing pass over all MAX_WIDTH entries of the row memory, during which it accepts no
// pixel transactions; line width writes are taken at any time but must only be issued while
// the block is idle. A pixel with image_start set clears all diffused error before it is
// processed.
module multilevel_error_diffusion_dither_top #(
   parameter int MAX_WIDTH = mded_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   mded_req_if.sink                      req_if,
   mded_rsp_if.source                    rsp_if,
   input  logic                          csr_wr_en,
   input  logic [mded_pkg::CSR_W-1:0]    csr_wr_data
);
   import mded_pkg::*;

   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W  = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   // Configuration.
   logic [CSR_W-1:0]   line_width_ff;
   logic [CMP_W-1:0]   lw_ext;
   logic [CMP_W-1:0]   width_eff;

   // Accept side: column and first-row tracking.
   logic               accept;
   logic [ADDR_W-1:0]  col_ff, col_in, col_use;
   logic               first_ff, first_in, first_use;
   logic [CMP_W-1:0]   col_plus;
   logic               last_w;

   // Quantize stage.
   logic               s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic               s1_start_ff;
   logic [ADDR_W-1:0]  s1_col_ff;
   logic               s1_last_ff;
   logic               s1_first_ff;
   logic               s1_adv;
   logic               byp_hit_ff;
   err_type            byp_data_ff;
   err_type            rd_data;
   err_type            below;
   err_type            carry_use, pend_left_use, pend_cur_use;
   quant_type          q;

   // Diffusion state carried from pixel to pixel.
   err_type            carry_ff, carry_in;
   err_type            pend_left_ff, pend_left_in;
   err_type            pend_cur_ff, pend_cur_in;

   // Held write of the last column of a row.
   logic               defer_valid_ff, defer_valid_in;
   logic [ADDR_W-1:0]  defer_addr_ff, defer_addr_in;
   err_type            defer_data_ff, defer_data_in;

   // Clearing pass after reset.
   logic               clr_active_ff, clr_active_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;

   // Memory write port.
   logic               s1_wr;
   logic [ADDR_W-1:0]  s1_wr_addr;
   err_type            s1_wr_data;
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   err_type            mem_wr_data;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PLANE_W-1:0] rsp_planes_ff;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic               rsp_row_end_ff;

   // The width in use is line_width limited to 1..MAX_WIDTH.
   assign lw_ext = CMP_W'(line_width_ff);
   always_comb begin
      priority if (lw_ext == '0) begin
         width_eff = CMP_W'(1);
      end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = lw_ext;
      end
   end

   // The quantize stage moves on whenever the response register is free or being emptied;
   // a new pixel enters whenever the quantize stage is free or moving on.
   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !clr_active_ff && (!s1_valid_ff || s1_adv);
   assign accept       = req_if.valid && req_if.ready;

   // Column position and first-row flag of the pixel being accepted. A row ends when the
   // next column would reach the width in use, which also covers a width that shrank below
   // the current column.
   assign col_use   = req_if.image_start ? '0 : col_ff;
   assign first_use = req_if.image_start ? 1'b1 : first_ff;
   assign col_plus  = CMP_W'(col_use) + CMP_W'(1);
   assign last_w    = (col_plus >= width_eff);
   assign col_in    = accept ? (last_w ? '0 : ADDR_W'(col_plus)) : col_ff;
   assign first_in  = accept ? (last_w ? 1'b0 : first_use) : first_ff;

   assign s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   // Read data is bypassed when the same entry was written at the edge of the read. No other
   // write can land while a pixel waits in the quantize stage, since writes only happen at
   // edges where that stage is empty or moving on.
   assign below = s1_first_ff ? '0 : (byp_hit_ff ? byp_data_ff : rd_data);

   // An image start discards the diffused error of the previous image.
   assign carry_use     = s1_start_ff ? '0 : carry_ff;
   assign pend_left_use = s1_start_ff ? '0 : pend_left_ff;
   assign pend_cur_use  = s1_start_ff ? '0 : pend_cur_ff;

   mded_quant u_quant (
      .pixel     (s1_pixel_ff),
      .carry     (carry_use),
      .below     (below),
      .pend_left (pend_left_use),
      .pend_cur  (pend_cur_use),
      .result    (q)
   );

   // The 3/16 share completes the entry of the column to the left; at the left edge it is
   // dropped. A one-pixel row finishes its own column directly.
   always_comb begin
      s1_wr      = 1'b0;
      s1_wr_addr = s1_col_ff;
      s1_wr_data = q.pend_left;
      if (s1_adv) begin
         if (s1_col_ff != '0) begin
            s1_wr      = 1'b1;
            s1_wr_addr = s1_col_ff - ADDR_W'(1);
            s1_wr_data = q.wr_left;
         end else if (s1_last_ff) begin
            s1_wr      = 1'b1;
         end
      end
   end

   // Write port priority: clearing pass, then the quantize stage, then the held write.
   always_comb begin
      defer_valid_in = defer_valid_ff;
      defer_addr_in  = defer_addr_ff;
      defer_data_in  = defer_data_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = clr_addr_ff;
      mem_wr_data    = '0;
      priority if (clr_active_ff) begin
         mem_wr_en = 1'b1;
      end else if (s1_wr) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = s1_wr_addr;
         mem_wr_data = s1_wr_data;
      end else if (defer_valid_ff && (!s1_valid_ff || s1_adv)) begin
         mem_wr_en      = 1'b1;
         mem_wr_addr    = defer_addr_ff;
         mem_wr_data    = defer_data_ff;
         defer_valid_in = 1'b0;
      end
      if (s1_adv && s1_last_ff && (s1_col_ff != '0)) begin
         defer_valid_in = 1'b1;
         defer_addr_in  = s1_col_ff;
         defer_data_in  = q.pend_left;
      end
   end

   mded_row_mem #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_row_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_use),
      .rd_data (rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // At a row end the running shares restart from zero.
   assign carry_in     = s1_adv ? (s1_last_ff ? '0 : q.carry)     : carry_ff;
   assign pend_left_in = s1_adv ? (s1_last_ff ? '0 : q.pend_left) : pend_left_ff;
   assign pend_cur_in  = s1_adv ? (s1_last_ff ? '0 : q.pend_cur)  : pend_cur_ff;

   assign clr_active_in = clr_active_ff && (clr_addr_ff != ADDR_W'(MAX_WIDTH - 1));
   assign clr_addr_in   = clr_active_ff ? clr_addr_ff + ADDR_W'(1) : clr_addr_ff;

   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= CSR_W'(LINE_WIDTH_RESET);
         col_ff         <= '0;
         first_ff       <= 1'b1;
         s1_valid_ff    <= 1'b0;
         carry_ff       <= '0;
         pend_left_ff   <= '0;
         pend_cur_ff    <= '0;
         defer_valid_ff <= 1'b0;
         clr_active_ff  <= 1'b1;
         clr_addr_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            line_width_ff <= csr_wr_data;
         end
         col_ff         <= col_in;
         first_ff       <= first_in;
         s1_valid_ff    <= s1_valid_in;
         carry_ff       <= carry_in;
         pend_left_ff   <= pend_left_in;
         pend_cur_ff    <= pend_cur_in;
         defer_valid_ff <= defer_valid_in;
         clr_active_ff  <= clr_active_in;
         clr_addr_ff    <= clr_addr_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_if.pixel;
         s1_start_ff <= req_if.image_start;
         s1_col_ff   <= col_use;
         s1_last_ff  <= last_w;
         s1_first_ff <= first_use;
         byp_hit_ff  <= mem_wr_en && (mem_wr_addr == col_use);
         byp_data_ff <= mem_wr_data;
      end
      defer_addr_ff <= defer_addr_in;
      defer_data_ff <= defer_data_in;
      if (s1_adv) begin
         rsp_planes_ff  <= q.planes;
         rsp_level_ff   <= q.level;
         rsp_row_end_ff <= s1_last_ff;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.planes  = rsp_planes_ff;
   assign rsp_if.level   = rsp_level_ff;
   assign rsp_if.row_end = rsp_row_end_ff;

`ifndef SYNTHESIS
   // No pixel may enter while the row memory is still being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !accept)
      else $error("pixel accepted during clearing pass");

   // The held row-end write must not be overtaken by a second row end while a quantize-stage write keeps it waiting.
   a_defer_no_clash: assert property (@(posedge clock) disable iff (reset)
      (defer_valid_ff && s1_wr) |-> !(s1_adv && s1_last_ff && (s1_col_ff != '0)))
      else $error("held write overtaken by a second row end");

   // A pixel waiting in the quantize stage must see no memory write behind its read.
   a_no_write_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |-> !mem_wr_en)
      else $error("row memory written under a stalled read");

   // The plane code is the thermometer form of the level.
   a_planes_match_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_level_ff <= LEVEL_W'(5)) &&
                       (rsp_planes_ff == PLANE_W'((6'd1 << rsp_level_ff) - 6'd1)))
      else $error("plane code does not match level");
`endif

endmodule

FILE: rtl/core/mded_row_mem.sv
// Next-row error memory: one write port, one read port with registered read data.
// Depends on mded_pkg for the error type.
module mded_row_mem #(
   parameter int DEPTH  = mded_pkg::MAX_WIDTH_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output mded_pkg::err_type   rd_data,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  mded_pkg::err_type   wr_data
);
   import mded_pkg::*;

   err_type mem [DEPTH];
   err_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/mded_quant.sv
// Quantizer and Floyd-Steinberg share computation for one pixel.
// Depends on mded_pkg for widths, constants, saturation and the result struct.
module mded_quant (
   input  logic [mded_pkg::PIXEL_W-1:0] pixel,
   input  mded_pkg::err_type            carry,
   input  mded_pkg::err_type            below,
   input  mded_pkg::err_type            pend_left,
   input  mded_pkg::err_type            pend_cur,
   output mded_pkg::quant_type          result
);
   import mded_pkg::*;

   logic signed [V_W-1:0]   v;
   logic [PLANE_W-1:0]      planes;
   logic [LEVEL_W-1:0]      level;
   logic signed [E_W-1:0]   e;
   logic signed [P_W-1:0]   e_x;
   logic signed [P_W-1:0]   p7;
   logic signed [P_W-1:0]   p5;
   logic signed [P_W-1:0]   p3;

   // Corrected value in 1/16 grey steps.
   assign v = V_W'($signed({1'b0, pixel, 4'b0000})) + V_W'(carry) + V_W'(below);

   // Each plane bit is one rounding threshold, halfway between two levels.
   always_comb begin
      for (int k = 0; k < PLANE_W; k++) begin
         planes[k] = (v >= $signed(V_W'(HALF16 + STEP16 * k)));
      end
   end

   assign level = planes_to_level(planes);
   assign e     = E_W'(v - level_base(level));

   assign e_x = P_W'(e);
   assign p7  = (e_x <<< 3) - e_x;
   assign p5  = (e_x <<< 2) + e_x;
   assign p3  = (e_x <<< 1) + e_x;

   // Arithmetic right shifts floor each share.
   assign result.planes    = planes;
   assign result.level     = level;
   assign result.carry     = sat12(p7 >>> 4);
   assign result.pend_cur  = sat12(e_x >>> 4);
   assign result.pend_left = sat12(SUM_W'(pend_cur) + (p5 >>> 4));
   assign result.wr_left   = sat12(SUM_W'(pend_left) + (p3 >>> 4));

endmodule
